/* rtl/oqs_pkg.sv */
`default_nettype none

package oqs_pkg;

  localparam int MODE_SLOTS = 4;
  localparam int FRAC_BITS  = 8;

  localparam int TIME_W  = 40;
  localparam int OUT_W   = 41;
  localparam int GAP_W   = 41;
  localparam int NOTE_W  = 8;
  localparam int MIX_W   = 9;
  localparam int SP_W    = 16;
  localparam int MODE_W  = 3;
  localparam int NUM_SP  = 4;
  localparam int MODE_LIM = (MODE_SLOTS < NUM_SP) ? MODE_SLOTS : NUM_SP;

  localparam int DIFF_W   = GAP_W + 1;
  localparam int PROD_W   = DIFF_W + MIX_W + 1;
  localparam int RND_SH   = 8;
  localparam int DELTA_W  = PROD_W - RND_SH;
  localparam int SUM_W    = DELTA_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 2;

  localparam logic [MIX_W-1:0]  MIX_FULL  = MIX_W'(256);
  localparam logic [MIX_W-1:0]  MIX_RESET = MIX_W'(192);
  localparam logic [NOTE_W-1:0] NOTE_CAPTURE_MAX = NOTE_W'(127);
  localparam logic [GAP_W-1:0]  CHORD_EPS = GAP_W'(2) << FRAC_BITS;
  localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX,
    REG_LEARNING,
    REG_MODE_COUNT,
    REG_SPACING_A,
    REG_SPACING_B,
    REG_SPACING_C,
    REG_SPACING_D
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_FIRST,
    KIND_CHORD,
    KIND_STEP
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic                     capture;
    logic [NOTE_W-1:0]        note;
    logic [TIME_W-1:0]        raw;
    logic signed [GAP_W-1:0]  gap;
  } item_t;

  typedef struct packed {
    logic [MIX_W-1:0]             mix;
    logic                         learning;
    logic [MODE_W-1:0]            mode_count;
    logic [NUM_SP-1:0][SP_W-1:0]  spacing;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/oqs_front.sv */
`default_nettype none

module oqs_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          learning_i,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic                          note_on_i,
  input  wire logic                          bend_i,
  input  wire logic [oqs_pkg::NOTE_W-1:0]    note_i,
  input  wire logic [oqs_pkg::TIME_W-1:0]    raw_i,
  input  wire logic                          q_ready_i,
  output logic                               push_o,
  output oqs_pkg::item_t                     item_o
);

  logic                             gvalid_q, gvalid_d;
  logic [oqs_pkg::TIME_W-1:0]       graw_q, graw_d;
  logic signed [oqs_pkg::GAP_W-1:0] gap;
  logic [oqs_pkg::GAP_W-1:0]        gap_abs;
  logic                             is_on;
  logic                             accept;

  assign ready_o = q_ready_i;
  assign accept  = valid_i && q_ready_i;
  assign push_o  = accept;
  assign is_on   = note_on_i && !bend_i;

  always_comb begin
    gap     = $signed({1'b0, raw_i}) - $signed({1'b0, graw_q});
    gap_abs = gap[oqs_pkg::GAP_W-1] ? oqs_pkg::GAP_W'(-gap) : oqs_pkg::GAP_W'(gap);

    item_o.kind    = oqs_pkg::KIND_PASS;
    item_o.capture = 1'b0;
    item_o.note    = note_i;
    item_o.raw     = raw_i;
    item_o.gap     = gap;

    gvalid_d = gvalid_q;
    graw_d   = graw_q;

    if (learning_i) begin
      item_o.capture = is_on && (note_i <= oqs_pkg::NOTE_CAPTURE_MAX);
    end else if (is_on) begin
      if (!gvalid_q) begin
        item_o.kind = oqs_pkg::KIND_FIRST;
      end else if (gap_abs < oqs_pkg::CHORD_EPS) begin
        item_o.kind = oqs_pkg::KIND_CHORD;
      end else begin
        item_o.kind = oqs_pkg::KIND_STEP;
      end
    end

    if (accept && (item_o.kind == oqs_pkg::KIND_FIRST || item_o.kind == oqs_pkg::KIND_STEP)) begin
      gvalid_d = 1'b1;
      graw_d   = raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gvalid_q <= 1'b0;
    end else begin
      gvalid_q <= gvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    graw_q <= graw_d;
  end

endmodule

`default_nettype wire

/* rtl/oqs_fifo.sv */
`default_nettype none

module oqs_fifo #(
  parameter int DEPTH = oqs_pkg::FIFO_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire oqs_pkg::item_t item_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output oqs_pkg::item_t      item_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  oqs_pkg::item_t     mem_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/oqs_back.sv */
`default_nettype none

module oqs_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire oqs_pkg::cfg_t                       cfg_i,
  input  wire logic                                q_valid_i,
  input  wire oqs_pkg::item_t                      q_item_i,
  output logic                                     pop_o,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output logic signed [oqs_pkg::OUT_W-1:0]         ticks_o,
  output logic                                     retimed_o,
  output logic                                     capture_o,
  output logic [oqs_pkg::NOTE_W-1:0]               note_o
);

  localparam int DW = oqs_pkg::DIFF_W;
  localparam int PW = oqs_pkg::PROD_W;
  localparam int LW = oqs_pkg::DELTA_W;
  localparam int SW = oqs_pkg::SUM_W;
  localparam int OW = oqs_pkg::OUT_W;

  // nearest-spacing stage
  logic                         n_valid_q;
  oqs_pkg::item_t               n_item_q;
  logic signed [DW-1:0]         n_diff_q, n_diff_d;
  // pull stage
  logic                         m_valid_q;
  oqs_pkg::item_t               m_item_q;
  logic signed [LW-1:0]         m_delta_q, m_delta_d;
  // group accumulator and output register
  logic                         o_valid_q;
  logic signed [OW-1:0]         o_ticks_q, o_ticks_d;
  logic                         o_retimed_q, o_capture_q;
  logic [oqs_pkg::NOTE_W-1:0]   o_note_q;
  logic signed [OW-1:0]         corr_q, corr_d;

  logic a_en, m_en, n_en;

  assign a_en  = !o_valid_q || ready_i;
  assign m_en  = !m_valid_q || a_en;
  assign n_en  = !n_valid_q || m_en;
  assign pop_o = q_valid_i && n_en;

  assign valid_o   = o_valid_q;
  assign ticks_o   = o_ticks_q;
  assign retimed_o = o_retimed_q;
  assign capture_o = o_capture_q;
  assign note_o    = o_note_q;

  always_comb begin
    logic [oqs_pkg::MODE_W-1:0] n_use;
    logic signed [DW-1:0]       gap_x;
    logic signed [DW-1:0]       sp_x;
    logic signed [DW-1:0]       d;
    logic [DW-1:0]              sp_dist;
    logic [DW-1:0]              best_d;
    logic signed [DW-1:0]       best_sp;
    n_use   = (cfg_i.mode_count > oqs_pkg::MODE_W'(oqs_pkg::MODE_LIM))
              ? oqs_pkg::MODE_W'(oqs_pkg::MODE_LIM) : cfg_i.mode_count;
    gap_x   = DW'($signed(q_item_i.gap));
    best_d  = '1;
    best_sp = '0;
    for (int i = 0; i < oqs_pkg::NUM_SP; i++) begin
      sp_x    = $signed(DW'({1'b0, cfg_i.spacing[i]}));
      d       = gap_x - sp_x;
      sp_dist = d[DW-1] ? DW'(-d) : DW'(d);
      if ((oqs_pkg::MODE_W'(i) < n_use) && (i == 0 || sp_dist < best_d)) begin
        best_d  = sp_dist;
        best_sp = sp_x;
      end
    end
    n_diff_d = (n_use == '0) ? '0 : best_sp - gap_x;
  end

  always_comb begin
    logic [oqs_pkg::MIX_W-1:0] m_eff;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      rnd;
    logic signed [LW-1:0]      pull;
    m_eff     = (cfg_i.mix > oqs_pkg::MIX_FULL) ? oqs_pkg::MIX_FULL : cfg_i.mix;
    prod      = $signed({1'b0, m_eff}) * n_diff_q;
    rnd       = prod + $signed(oqs_pkg::RND_HALF);
    pull      = $signed(rnd[PW-1:oqs_pkg::RND_SH]);
    m_delta_d = LW'($signed(n_item_q.gap)) + pull;
  end

  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [OW-1:0] sat;
    logic signed [OW-1:0] raw_x;
    sum   = SW'(corr_q) + SW'(m_delta_q);
    raw_x = $signed({1'b0, m_item_q.raw});
    if (sum[SW-1:OW-1] == '0 || sum[SW-1:OW-1] == '1) begin
      sat = sum[OW-1:0];
    end else if (sum[SW-1]) begin
      sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OW-1){1'b1}}};
    end
    corr_d    = corr_q;
    o_ticks_d = raw_x;
    case (m_item_q.kind)
      oqs_pkg::KIND_PASS: begin
        o_ticks_d = raw_x;
      end
      oqs_pkg::KIND_FIRST: begin
        corr_d    = raw_x;
        o_ticks_d = raw_x;
      end
      oqs_pkg::KIND_CHORD: begin
        o_ticks_d = corr_q;
      end
      oqs_pkg::KIND_STEP: begin
        corr_d    = sat;
        o_ticks_d = sat;
      end
      default: begin
        o_ticks_d = raw_x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (n_en) begin
        n_valid_q <= q_valid_i;
      end
      if (m_en) begin
        m_valid_q <= n_valid_q;
      end
      if (a_en) begin
        o_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      n_item_q <= q_item_i;
      n_diff_q <= n_diff_d;
    end
    if (m_en && n_valid_q) begin
      m_item_q  <= n_item_q;
      m_delta_q <= m_delta_d;
    end
    if (a_en && m_valid_q) begin
      corr_q      <= corr_d;
      o_ticks_q   <= o_ticks_d;
      o_retimed_q <= (m_item_q.kind != oqs_pkg::KIND_PASS);
      o_capture_q <= m_item_q.capture;
      o_note_q    <= m_item_q.note;
    end
  end

endmodule

`default_nettype wire

/* rtl/onset_spacing_quantizer.sv */
// Throughput: one transfer per cycle on each side, sustained while m_axis_tready is high.
// A result reaches the master side through the queue, the nearest-spacing stage,
// the pull stage, then the group accumulator/output register.
// The onset group is tracked in order, so back-to-back note-ons never stall.
// Reset (rst_ni low, async): no onset group, queue and pipeline empty,
// mix = 192, learning = 0, mode_count = 0, all spacings 0.
`default_nettype none

module onset_spacing_quantizer #(
  parameter int FIFO_DEPTH = oqs_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // note[7:0], onset_ticks[47:8]
  input  wire logic [1:0]  s_axis_tuser,   // is_note_on[0], is_bend_update[1]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // out_ticks[40:0], note_out[48:41], zero[55:49]
  output logic [1:0]       m_axis_tuser,   // retimed[0], capture[1]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [oqs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [oqs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  oqs_pkg::cfg_t   cfg_q;
  oqs_pkg::item_t  f_item, q_item;
  logic            f_push, q_ready, q_valid, q_pop;
  logic            b_retimed, b_capture;
  logic signed [oqs_pkg::OUT_W-1:0]  b_ticks;
  logic [oqs_pkg::NOTE_W-1:0]        b_note;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix        <= oqs_pkg::MIX_RESET;
      cfg_q.learning   <= 1'b0;
      cfg_q.mode_count <= '0;
      cfg_q.spacing    <= '0;
    end else if (cfg_valid_i) begin
      case (oqs_pkg::reg_idx_e'(cfg_index_i))
        oqs_pkg::REG_MIX:        cfg_q.mix        <= cfg_data_i[oqs_pkg::MIX_W-1:0];
        oqs_pkg::REG_LEARNING:   cfg_q.learning   <= cfg_data_i[0];
        oqs_pkg::REG_MODE_COUNT: cfg_q.mode_count <= cfg_data_i[oqs_pkg::MODE_W-1:0];
        oqs_pkg::REG_SPACING_A:  cfg_q.spacing[0] <= cfg_data_i;
        oqs_pkg::REG_SPACING_B:  cfg_q.spacing[1] <= cfg_data_i;
        oqs_pkg::REG_SPACING_C:  cfg_q.spacing[2] <= cfg_data_i;
        oqs_pkg::REG_SPACING_D:  cfg_q.spacing[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  oqs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .learning_i (cfg_q.learning),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .note_on_i  (s_axis_tuser[0]),
    .bend_i     (s_axis_tuser[1]),
    .note_i     (s_axis_tdata[7:0]),
    .raw_i      (s_axis_tdata[47:8]),
    .q_ready_i  (q_ready),
    .push_o     (f_push),
    .item_o     (f_item)
  );

  oqs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  oqs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (q_pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .ticks_o   (b_ticks),
    .retimed_o (b_retimed),
    .capture_o (b_capture),
    .note_o    (b_note)
  );

  assign m_axis_tdata = {7'd0, b_note, b_ticks};
  assign m_axis_tuser = {b_capture, b_retimed};

endmodule

`default_nettype wire
